[rtl/irrgb_pkg.sv]
// ----------------------------------------------------------------------------
// irrgb_pkg
// Shared types and constants for the ir remote rgb color controller.
// ----------------------------------------------------------------------------
package irrgb_pkg;

	// level format: unsigned 8.8
	localparam logic [15:0] LVL_MAX   = 16'hFF00;
	localparam logic [15:0] LVL_ONE   = 16'h0100;
	localparam logic [7:0]  FRAC_INIT = 8'd64;

	// fade phase codes
	localparam logic [1:0] PH_OFF   = 2'd0;
	localparam logic [1:0] PH_RED   = 2'd1;
	localparam logic [1:0] PH_GREEN = 2'd2;
	localparam logic [1:0] PH_BLUE  = 2'd3;

	// request kinds
	localparam logic FUNC_TICK = 1'b0;
	localparam logic FUNC_KEY  = 1'b1;

	// remote key codes
	localparam logic [31:0] KEY_TINT     = 32'h00FD50AF;
	localparam logic [31:0] KEY_SHADE    = 32'h00FD10EF;
	localparam logic [31:0] KEY_FADE     = 32'h00FDB04F;
	localparam logic [31:0] KEY_POWER    = 32'h00FD00FF;
	localparam logic [31:0] KEY_WHITE    = 32'h00FD30CF;
	localparam logic [31:0] KEY_RED      = 32'h00FD08F7;
	localparam logic [31:0] KEY_MAGENTA  = 32'h00FD28D7;
	localparam logic [31:0] KEY_LAVENDER = 32'h00FD18E7;
	localparam logic [31:0] KEY_GREEN    = 32'h00FD8877;
	localparam logic [31:0] KEY_ORANGE   = 32'h00FDA857;
	localparam logic [31:0] KEY_YELLOW   = 32'h00FD9867;
	localparam logic [31:0] KEY_BLUE     = 32'h00FD48B7;
	localparam logic [31:0] KEY_SKY      = 32'h00FD6897;
	localparam logic [31:0] KEY_CYAN     = 32'h00FD58A7;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_TINT,
		OP_SHADE,
		OP_FADE,
		OP_POWER,
		OP_LOAD
	} op_t;

	// decoded key: operation plus preset color
	typedef struct packed {
		op_t        op;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} key_op_t;

	// per-channel command
	typedef struct packed {
		op_t        op;
		logic [7:0] preset;
		logic       step;
	} chan_cmd_t;

endpackage

[rtl/irrgb_req_if.sv]
// ----------------------------------------------------------------------------
// irrgb_req_if
// Request channel: tick or remote key code.
// ----------------------------------------------------------------------------
interface irrgb_req_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [31:0] key_code;

	modport source (output valid, output func, output key_code, input ready);
	modport sink   (input valid, input func, input key_code, output ready);
endinterface

[rtl/irrgb_rsp_if.sv]
// ----------------------------------------------------------------------------
// irrgb_rsp_if
// Result channel: led drive levels and update flag.
// ----------------------------------------------------------------------------
interface irrgb_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] pwm_red;
	logic [7:0] pwm_green;
	logic [7:0] pwm_blue;
	logic       drive_update;

	modport source (output valid, output pwm_red, output pwm_green, output pwm_blue,
		output drive_update, input ready);
	modport sink   (input valid, input pwm_red, input pwm_green, input pwm_blue,
		input drive_update, output ready);
endinterface

[rtl/irrgb_cfg_if.sv]
// ----------------------------------------------------------------------------
// irrgb_cfg_if
// Configuration write channel for the tint/shade fraction.
// ----------------------------------------------------------------------------
interface irrgb_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] tint_shade_fraction;

	modport source (output valid, output tint_shade_fraction, input ready);
	modport sink   (input valid, input tint_shade_fraction, output ready);
endinterface

[rtl/irrgb_dec.sv]
// ----------------------------------------------------------------------------
// irrgb_dec
// Decodes a remote key code into an operation and preset color.
// ----------------------------------------------------------------------------
module irrgb_dec (
	input  logic              func,
	input  logic [31:0]       key_code,
	output irrgb_pkg::key_op_t key_op
);
	import irrgb_pkg::*;

	// key lookup, ticks decode to no operation
	always_comb begin
		key_op = '{op: OP_NONE, red: 8'd0, green: 8'd0, blue: 8'd0};
		if (func == FUNC_KEY) begin
			case (key_code)
				KEY_TINT:     key_op.op = OP_TINT;
				KEY_SHADE:    key_op.op = OP_SHADE;
				KEY_FADE:     key_op.op = OP_FADE;
				KEY_POWER:    key_op.op = OP_POWER;
				KEY_WHITE:    key_op = '{OP_LOAD, 8'd255, 8'd255, 8'd255};
				KEY_RED:      key_op = '{OP_LOAD, 8'd255, 8'd0,   8'd0};
				KEY_MAGENTA:  key_op = '{OP_LOAD, 8'd255, 8'd0,   8'd255};
				KEY_LAVENDER: key_op = '{OP_LOAD, 8'd152, 8'd69,  8'd170};
				KEY_GREEN:    key_op = '{OP_LOAD, 8'd0,   8'd255, 8'd0};
				KEY_ORANGE:   key_op = '{OP_LOAD, 8'd200, 8'd100, 8'd0};
				KEY_YELLOW:   key_op = '{OP_LOAD, 8'd255, 8'd255, 8'd0};
				KEY_BLUE:     key_op = '{OP_LOAD, 8'd0,   8'd0,   8'd255};
				KEY_SKY:      key_op = '{OP_LOAD, 8'd12,  8'd93,  8'd219};
				KEY_CYAN:     key_op = '{OP_LOAD, 8'd0,   8'd255, 8'd255};
				default:      key_op.op = OP_NONE;
			endcase
		end
	end

endmodule

[rtl/irrgb_chan.sv]
// ----------------------------------------------------------------------------
// irrgb_chan
// One color channel: 8.8 level register with tint, shade, preset and fade step.
// ----------------------------------------------------------------------------
module irrgb_chan (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  irrgb_pkg::chan_cmd_t cmd,
	input  logic [7:0]           fraction,
	output logic [15:0]          level_q,
	output logic [15:0]          level_d,
	output logic                 wrap
);
	import irrgb_pkg::*;

	logic [15:0] gap;
	logic [15:0] mul_a;
	logic [23:0] product;
	logic [16:0] stepped;

	// shared scaler: gap to white for tint, level itself for shade
	assign gap     = (level_q >= LVL_MAX) ? 16'd0 : (LVL_MAX - level_q);
	assign mul_a   = (cmd.op == OP_TINT) ? gap : level_q;
	assign product = mul_a * fraction;

	// fade step wraps to zero on reaching full scale
	assign stepped = {1'b0, level_q} + {1'b0, LVL_ONE};
	assign wrap    = (stepped >= {1'b0, LVL_MAX});

	// next level
	always_comb begin
		level_d = level_q;
		if (cmd.step) begin
			level_d = wrap ? 16'd0 : stepped[15:0];
		end else begin
			case (cmd.op)
				OP_TINT:  level_d = level_q + product[23:8];
				OP_SHADE: level_d = product[23:8];
				OP_LOAD:  level_d = {cmd.preset, 8'd0};
				default:  level_d = level_q;
			endcase
		end
	end

	// level register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= LVL_MAX;
		end else if (en) begin
			level_q <= level_d;
		end
	end

endmodule

[rtl/ir_remote_rgb_color_controller_core.sv]
// An accepted request is held in the input register, then its result in the result register.
// Throughput: one request per cycle unless rsp stalls; one is taken while a result waits.
// The state update and result are computed combinationally from the input register.
// Reset: levels 255.0, power off, fading off, fraction 64; no clearing pass.
// ----------------------------------------------------------------------------
// ir_remote_rgb_color_controller_core
// Remote-controlled rgb color controller: presets, tint, shade, fade and power.
// ----------------------------------------------------------------------------
module ir_remote_rgb_color_controller_core (
	input  logic  clk,
	input  logic  arst_n,
	irrgb_req_if.sink   req,
	irrgb_rsp_if.source rsp,
	irrgb_cfg_if.sink   cfg
);
	import irrgb_pkg::*;

	logic        valid_s1;
	logic        func_s1;
	logic [31:0] key_s1;
	logic        advance;
	logic        commit;
	logic [7:0]  fraction_q;
	logic        power_q;
	logic [1:0]  phase_q;
	logic        power_d;
	logic [1:0]  phase_d;
	logic        tick_act;
	logic        upd;
	key_op_t     key_op;
	chan_cmd_t   cmd_r;
	chan_cmd_t   cmd_g;
	chan_cmd_t   cmd_b;
	logic [15:0] red_q;
	logic [15:0] green_q;
	logic [15:0] blue_q;
	logic [15:0] red_d;
	logic [15:0] green_d;
	logic [15:0] blue_d;
	logic        wrap_r;
	logic        wrap_g;
	logic        wrap_b;
	logic        rsp_valid_q;
	logic [7:0]  pwm_red_q;
	logic [7:0]  pwm_green_q;
	logic [7:0]  pwm_blue_q;
	logic        upd_q;

	// handshake
	assign advance   = !rsp_valid_q || rsp.ready;
	assign commit    = valid_s1 && advance;
	assign req.ready = !valid_s1 || advance;
	assign cfg.ready = 1'b1;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fraction_q <= FRAC_INIT;
		end else if (cfg.valid) begin
			fraction_q <= cfg.tint_shade_fraction;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			func_s1 <= req.func;
			key_s1  <= req.key_code;
		end
	end

	// key decode
	irrgb_dec u_dec (
		.func     (func_s1),
		.key_code (key_s1),
		.key_op   (key_op)
	);

	// fade tick steps the active channel only
	assign tick_act = (func_s1 == FUNC_TICK) && (phase_q != PH_OFF) && power_q;

	assign cmd_r = '{op: key_op.op, preset: key_op.red,
		step: tick_act && (phase_q == PH_RED)};
	assign cmd_g = '{op: key_op.op, preset: key_op.green,
		step: tick_act && (phase_q == PH_GREEN)};
	assign cmd_b = '{op: key_op.op, preset: key_op.blue,
		step: tick_act && (phase_q == PH_BLUE)};

	irrgb_chan u_red (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (commit),
		.cmd      (cmd_r),
		.fraction (fraction_q),
		.level_q  (red_q),
		.level_d  (red_d),
		.wrap     (wrap_r)
	);

	irrgb_chan u_green (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (commit),
		.cmd      (cmd_g),
		.fraction (fraction_q),
		.level_q  (green_q),
		.level_d  (green_d),
		.wrap     (wrap_g)
	);

	irrgb_chan u_blue (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (commit),
		.cmd      (cmd_b),
		.fraction (fraction_q),
		.level_q  (blue_q),
		.level_d  (blue_d),
		.wrap     (wrap_b)
	);

	// power, fade phase and update flag
	always_comb begin
		power_d = power_q;
		phase_d = phase_q;
		upd     = 1'b0;
		if (func_s1 == FUNC_TICK) begin
			upd = tick_act;
			if (tick_act) begin
				case (phase_q)
					PH_RED:   phase_d = wrap_r ? PH_GREEN : PH_RED;
					PH_GREEN: phase_d = wrap_g ? PH_BLUE : PH_GREEN;
					PH_BLUE:  phase_d = wrap_b ? PH_RED : PH_BLUE;
					default:  phase_d = phase_q;
				endcase
			end
		end else begin
			case (key_op.op)
				OP_FADE:  phase_d = (phase_q != PH_OFF) ? PH_OFF : PH_RED;
				OP_POWER: power_d = !power_q;
				default:  phase_d = phase_q;
			endcase
			upd = (key_op.op == OP_POWER) || power_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			power_q <= 1'b0;
			phase_q <= PH_OFF;
		end else if (commit) begin
			power_q <= power_d;
			phase_q <= phase_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			pwm_red_q   <= power_d ? red_d[15:8] : 8'd0;
			pwm_green_q <= power_d ? green_d[15:8] : 8'd0;
			pwm_blue_q  <= power_d ? blue_d[15:8] : 8'd0;
			upd_q       <= upd;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.pwm_red      = pwm_red_q;
	assign rsp.pwm_green    = pwm_green_q;
	assign rsp.pwm_blue     = pwm_blue_q;
	assign rsp.drive_update = upd_q;

endmodule

[tb/ir_remote_rgb_color_controller_core_tb.sv]
// ----------------------------------------------------------------------------
// ir_remote_rgb_color_controller_core_tb
// Self-checking bench for the remote rgb color controller: a directed table of
// ticks and key codes, then random key and tick streams under six fraction
// settings. Every request is run through a local model of the channel levels,
// power and fade phase, and each result is compared field by field in order.
// ----------------------------------------------------------------------------
module ir_remote_rgb_color_controller_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import irrgb_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_PER_PHASE = 267;
	localparam int HOLD_CYCLES = 80;
	localparam bit TYPED = 1'b1;
	localparam bit PREDICT = 1'b0;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       upd;
	} drive_t;

	typedef struct packed {
		logic        func;
		logic [31:0] key;
		logic        typed;
		drive_t      want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;

	irrgb_req_if req_if();
	irrgb_rsp_if rsp_if();
	irrgb_cfg_if cfg_if();

	ir_remote_rgb_color_controller_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if),
		.cfg    (cfg_if)
	);

	// model state
	logic [15:0] lvl_red;
	logic [15:0] lvl_green;
	logic [15:0] lvl_blue;
	logic        power;
	logic [1:0]  phase;
	logic [7:0]  fraction;

	drive_t drive_q[$];
	int     errors = 0;
	int     cycles = 0;
	int     snd_idle_pct = 0;
	int     rcv_idle_pct = 0;
	bit     hold_kick = 1'b0;

	dir_row_t dir_rows [0:25];

	always #5ns clk = ~clk;

	task automatic report_error(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		errors++;
	endtask

	function automatic logic [15:0] shaded(input logic [15:0] c);
		logic [23:0] p;
		p = c * fraction;
		return p[23:8];
	endfunction

	// gap to white counts as zero at or above full scale
	function automatic logic [15:0] tinted(input logic [15:0] c);
		logic [15:0] gap;
		logic [23:0] p;
		gap = (c >= LVL_MAX) ? 16'd0 : LVL_MAX - c;
		p = gap * fraction;
		return c + p[23:8];
	endfunction

	// one fade step; a zero result means the channel wrapped
	function automatic logic [15:0] bumped(input logic [15:0] c);
		logic [16:0] v;
		v = c + LVL_ONE;
		return (v >= LVL_MAX) ? 16'd0 : v[15:0];
	endfunction

	function automatic void load_color(input logic [7:0] r, input logic [7:0] g,
		input logic [7:0] b);
		lvl_red = {r, 8'h00};
		lvl_green = {g, 8'h00};
		lvl_blue = {b, 8'h00};
	endfunction

	// advance the model by one request and return the drive it produces
	function automatic drive_t step_levels(input logic f, input logic [31:0] k);
		drive_t d;
		d.upd = 1'b0;
		if (f == FUNC_TICK) begin
			if (phase != PH_OFF && power) begin
				case (phase)
					PH_RED: begin
						lvl_red = bumped(lvl_red);
						if (lvl_red == 16'd0) phase = PH_GREEN;
					end
					PH_GREEN: begin
						lvl_green = bumped(lvl_green);
						if (lvl_green == 16'd0) phase = PH_BLUE;
					end
					default: begin
						lvl_blue = bumped(lvl_blue);
						if (lvl_blue == 16'd0) phase = PH_RED;
					end
				endcase
				d.upd = 1'b1;
			end
		end else begin
			case (k)
				KEY_TINT: begin
					lvl_red = tinted(lvl_red);
					lvl_green = tinted(lvl_green);
					lvl_blue = tinted(lvl_blue);
				end
				KEY_SHADE: begin
					lvl_red = shaded(lvl_red);
					lvl_green = shaded(lvl_green);
					lvl_blue = shaded(lvl_blue);
				end
				KEY_FADE: phase = (phase != PH_OFF) ? PH_OFF : PH_RED;
				KEY_POWER: begin
					power = ~power;
					d.upd = 1'b1;
				end
				KEY_WHITE:    load_color(8'd255, 8'd255, 8'd255);
				KEY_RED:      load_color(8'd255, 8'd0, 8'd0);
				KEY_MAGENTA:  load_color(8'd255, 8'd0, 8'd255);
				KEY_LAVENDER: load_color(8'd152, 8'd69, 8'd170);
				KEY_GREEN:    load_color(8'd0, 8'd255, 8'd0);
				KEY_ORANGE:   load_color(8'd200, 8'd100, 8'd0);
				KEY_YELLOW:   load_color(8'd255, 8'd255, 8'd0);
				KEY_BLUE:     load_color(8'd0, 8'd0, 8'd255);
				KEY_SKY:      load_color(8'd12, 8'd93, 8'd219);
				KEY_CYAN:     load_color(8'd0, 8'd255, 8'd255);
				default: ;
			endcase
			if (power) d.upd = 1'b1;
		end
		d.red = power ? lvl_red[15:8] : 8'd0;
		d.green = power ? lvl_green[15:8] : 8'd0;
		d.blue = power ? lvl_blue[15:8] : 8'd0;
		return d;
	endfunction

	function automatic dir_row_t dir_step(input logic f, input logic [31:0] k,
		input logic typed, input int r, input int g, input int b, input int u);
		dir_row_t row;
		row.func = f;
		row.key = k;
		row.typed = typed;
		row.want = '{r[7:0], g[7:0], b[7:0], u[0]};
		return row;
	endfunction

	function automatic logic [31:0] preset_key(input int unsigned i);
		case (i)
			0: return KEY_WHITE;
			1: return KEY_RED;
			2: return KEY_MAGENTA;
			3: return KEY_LAVENDER;
			4: return KEY_GREEN;
			5: return KEY_ORANGE;
			6: return KEY_YELLOW;
			7: return KEY_BLUE;
			8: return KEY_SKY;
			default: return KEY_CYAN;
		endcase
	endfunction

	// mostly powered and fading streams, with unknown and near-miss codes mixed in
	task automatic pick_request(output logic f, output logic [31:0] k);
		int unsigned r;
		r = $urandom_range(99);
		f = FUNC_KEY;
		if (!power && r < 40) begin
			k = KEY_POWER;
		end else if (phase == PH_OFF && r < 30) begin
			k = KEY_FADE;
		end else begin
			r = $urandom_range(99);
			if (r < 50) begin
				f = FUNC_TICK;
				k = $urandom;
			end else if (r < 60) k = KEY_TINT;
			else if (r < 66) k = KEY_SHADE;
			else if (r < 68) k = KEY_POWER;
			else if (r < 70) k = KEY_FADE;
			else if (r < 85) k = preset_key($urandom_range(9));
			else if (r < 93) k = $urandom;
			else k = preset_key($urandom_range(9)) ^ (32'h1 << $urandom_range(31));
		end
	endtask

	// offer one request, optionally after a gap, and predict it on acceptance
	task automatic send_request(input logic f, input logic [31:0] k, input bit typed,
		input drive_t want);
		drive_t pred;
		if (snd_idle_pct != 0 && $urandom_range(99) < snd_idle_pct) begin
			req_if.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.func <= f;
		req_if.key_code <= k;
		do @(posedge clk); while (!req_if.ready);
		pred = step_levels(f, k);
		drive_q.push_back(typed ? want : pred);
		@(negedge clk);
	endtask

	// stop offering and wait for every pending result
	task automatic drain_results();
		req_if.valid <= 1'b0;
		while (drive_q.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_fraction(input logic [7:0] v);
		cfg_if.valid <= 1'b1;
		cfg_if.tint_shade_fraction <= v;
		do @(posedge clk); while (!cfg_if.ready);
		fraction = v;
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	// result sink: random stalls plus an occasional long hold-off
	initial begin : result_sink
		int hold_left;
		bit hold_seen;
		hold_left = 0;
		hold_seen = 1'b0;
		rsp_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_kick != hold_seen) begin
				hold_seen = hold_kick;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
			end
		end
	end

	// compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		drive_t got;
		drive_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			got = '{rsp_if.pwm_red, rsp_if.pwm_green, rsp_if.pwm_blue, rsp_if.drive_update};
			if (drive_q.size() == 0) begin
				report_error($sformatf("result with nothing expected: %h", got));
			end else begin
				want = drive_q.pop_front();
				if (got.red !== want.red)
					report_error($sformatf("pwm_red got %0d want %0d", got.red, want.red));
				if (got.green !== want.green)
					report_error($sformatf("pwm_green got %0d want %0d", got.green,
						want.green));
				if (got.blue !== want.blue)
					report_error($sformatf("pwm_blue got %0d want %0d", got.blue, want.blue));
				if (got.upd !== want.upd)
					report_error($sformatf("drive_update got %0d want %0d", got.upd,
						want.upd));
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL ir_remote_rgb_color_controller_core");
			$finish;
		end
	end

	initial begin : stimulus
		int i;
		int n;
		int ph;
		logic f;
		logic [31:0] k;
		logic [7:0] frac_plan [0:5];

		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.func = FUNC_TICK;
		req_if.key_code = 32'd0;
		cfg_if.valid = 1'b0;
		cfg_if.tint_shade_fraction = 8'd0;

		lvl_red = LVL_MAX;
		lvl_green = LVL_MAX;
		lvl_blue = LVL_MAX;
		power = 1'b0;
		phase = PH_OFF;
		fraction = FRAC_INIT;

		frac_plan = '{8'd0, 8'd255, 8'($urandom_range(255)), 8'd128, 8'd1,
			8'($urandom_range(2, 254))};

		// power-off cases, toggles, presets and the red wrap into green
		dir_rows = '{
			dir_step(FUNC_TICK, 32'h0,         TYPED,   0,   0,   0, 0),
			dir_step(FUNC_KEY,  32'h0,         TYPED,   0,   0,   0, 0),
			dir_step(FUNC_KEY,  32'hFFFF_FFFF, TYPED,   0,   0,   0, 0),
			dir_step(FUNC_KEY,  KEY_FADE,      TYPED,   0,   0,   0, 0),
			dir_step(FUNC_TICK, 32'hFFFF_FFFF, TYPED,   0,   0,   0, 0),
			dir_step(FUNC_KEY,  KEY_FADE,      TYPED,   0,   0,   0, 0),
			dir_step(FUNC_KEY,  KEY_POWER,     TYPED, 255, 255, 255, 1),
			dir_step(FUNC_KEY,  KEY_TINT,      TYPED, 255, 255, 255, 1),
			dir_step(FUNC_TICK, 32'h0,         TYPED, 255, 255, 255, 0),
			dir_step(FUNC_KEY,  KEY_SHADE,     PREDICT, 0,   0,   0, 0),
			dir_step(FUNC_KEY,  KEY_TINT,      PREDICT, 0,   0,   0, 0),
			dir_step(FUNC_KEY,  KEY_WHITE,     TYPED, 255, 255, 255, 1),
			dir_step(FUNC_KEY,  KEY_RED,       TYPED, 255,   0,   0, 1),
			dir_step(FUNC_KEY,  KEY_FADE,      TYPED, 255,   0,   0, 1),
			dir_step(FUNC_TICK, 32'h0,         TYPED,   0,   0,   0, 1),
			dir_step(FUNC_TICK, 32'h0,         TYPED,   0,   1,   0, 1),
			dir_step(FUNC_TICK, KEY_POWER,     TYPED,   0,   2,   0, 1),
			dir_step(FUNC_KEY,  KEY_MAGENTA,   TYPED, 255,   0, 255, 1),
			dir_step(FUNC_KEY,  KEY_LAVENDER,  TYPED, 152,  69, 170, 1),
			dir_step(FUNC_KEY,  KEY_GREEN,     TYPED,   0, 255,   0, 1),
			dir_step(FUNC_KEY,  KEY_ORANGE,    TYPED, 200, 100,   0, 1),
			dir_step(FUNC_KEY,  KEY_YELLOW,    TYPED, 255, 255,   0, 1),
			dir_step(FUNC_KEY,  KEY_BLUE,      TYPED,   0,   0, 255, 1),
			dir_step(FUNC_KEY,  KEY_SKY,       TYPED,  12,  93, 219, 1),
			dir_step(FUNC_KEY,  KEY_CYAN,      TYPED,   0, 255, 255, 1),
			dir_step(FUNC_KEY,  KEY_POWER,     TYPED,   0,   0,   0, 1)
		};

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table at the default fraction
		snd_idle_pct = 23;
		rcv_idle_pct = 54;
		for (i = 0; i < 26; i++)
			send_request(dir_rows[i].func, dir_rows[i].key, dir_rows[i].typed,
				dir_rows[i].want);

		// random streams, one fraction setting per phase
		for (ph = 0; ph < 6; ph++) begin
			drain_results();
			write_fraction(frac_plan[ph]);
			case (ph % 3)
				0: begin
					snd_idle_pct = 23;
					rcv_idle_pct = 54;
				end
				1: begin
					snd_idle_pct = 54;
					rcv_idle_pct = 23;
				end
				default: begin
					snd_idle_pct = 0;
					rcv_idle_pct = 0;
				end
			endcase
			for (n = 0; n < RANDOM_PER_PHASE; n++) begin
				// back up the block while requests keep coming
				if (n == 100 && ph % 3 == 2) hold_kick = ~hold_kick;
				if (n == 180) drain_results();
				pick_request(f, k);
				send_request(f, k, PREDICT, '0);
			end
		end

		drain_results();
		repeat (8) @(posedge clk);
		if (errors == 0) begin
			$display("PASS ir_remote_rgb_color_controller_core");
		end else begin
			$display("FAIL ir_remote_rgb_color_controller_core");
		end
		$finish;
	end

endmodule
